### design/firlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// firlc_pkg
// shared constants, codes and command/status types of the linear convolution
// fir block
// ----------------------------------------------------------------------------
package firlc_pkg;

	// default sizes
	localparam int MAX_TAPS_DEF    = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int IDX_W  = 6;   // tap_index
	localparam int TAPC_W = 7;   // tap_count register

	localparam logic [TAPC_W-1:0] TAPC_RST = 7'd64;

	// action codes carried on tuser
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// address width of a store with n entries
	function automatic int addr_bits(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// controller to datapath
	typedef struct packed {
		logic coef_wr;     // write the coefficient from the input transfer
		logic hist_push;   // write a sample at the history head
		logic push_zero;   // pushed sample is zero (tail)
		logic issue;       // read one tap pair into the mac
		logic first;       // first tap of an output
		logic last_tap;    // final tap of an output
		logic out_load;    // move the result into the output register
		logic out_last;    // result closes the block
		logic hist_clear;  // empty the history line
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic res_rdy;     // rounded result waiting
		logic out_free;    // output register can take a result
	} dp_sts_t;

endpackage
`default_nettype wire

### design/firlc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// firlc_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module firlc_ram import firlc_pkg::*; #(
	parameter int WIDTH = SAMPLE_BITS_DEF,
	parameter int DEPTH = MAX_TAPS_DEF,
	localparam int AW = addr_bits(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

### design/firlc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// firlc_ctrl
// sequencer: input transfers, tap walk, tail outputs and result hand-over
// ----------------------------------------------------------------------------
module firlc_ctrl import firlc_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF,
	localparam int AW  = addr_bits(MAX_TAPS),
	localparam int TCW = $clog2(MAX_TAPS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [TAPC_W-1:0] cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              in_action,
	input  wire logic              in_end,
	output dp_cmd_t                cmd,
	output logic      [AW-1:0]     coef_raddr,
	input  wire dp_sts_t           sts
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_TAIL = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic [TAPC_W-1:0] tap_count_q;
	logic [AW-1:0]     k_q, k_d;
	logic [AW-1:0]     tail_q, tail_d;
	logic              end_q, end_d;
	logic [TCW-1:0]    taps;
	logic              accept;

	// taps in use: zero acts as one, above the line length acts as the length
	always_comb begin
		if (tap_count_q == '0) begin
			taps = TCW'(1);
		end else if (int'(tap_count_q) > MAX_TAPS) begin
			taps = TCW'(MAX_TAPS);
		end else begin
			taps = tap_count_q[TCW-1:0];
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign coef_raddr = k_q;

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		tail_d  = tail_q;
		end_d   = end_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_action == ACT_LOAD) begin
						cmd.coef_wr = 1'b1;
					end else begin
						cmd.hist_push = 1'b1;
						end_d         = in_end;
						tail_d        = in_end ? AW'(taps - TCW'(1)) : '0;
						k_d           = '0;
						state_d       = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				cmd.issue    = 1'b1;
				cmd.first    = (k_q == '0);
				cmd.last_tap = (TCW'(k_q) + TCW'(1) == taps);
				if (cmd.last_tap) begin
					state_d = ST_WAIT;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_WAIT: begin
				if (sts.res_rdy && sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = end_q && (tail_q == '0);
					if (cmd.out_last) begin
						cmd.hist_clear = 1'b1;
						end_d          = 1'b0;
						state_d        = ST_IDLE;
					end else if (end_q) begin
						tail_d  = tail_q - 1'b1;
						state_d = ST_TAIL;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_TAIL: begin
				cmd.hist_push = 1'b1;
				cmd.push_zero = 1'b1;
				k_d           = '0;
				state_d       = ST_RUN;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			tail_q      <= '0;
			end_q       <= 1'b0;
			tap_count_q <= TAPC_RST;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			tail_q  <= tail_d;
			end_q   <= end_d;
			if (cfg_we) begin
				tap_count_q <= cfg_wdata;
			end
		end
	end

`ifndef ASSERT_OFF
	a_load_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (sts.res_rdy && sts.out_free))
		else $error("result moved to output without a free slot");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hist_clear |-> (cmd.out_load && cmd.out_last))
		else $error("history cleared away from the final output");

	a_tap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (TCW'(k_q) < taps))
		else $error("tap walk beyond taps in use");

	a_idle_no_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (tail_q == '0 && !end_q))
		else $error("idle with tail outputs still owed");
`endif

endmodule
`default_nettype wire

### design/firlc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// firlc_dp
// coefficient and history stores, shared multiply-accumulate, rounding and
// output register
// ----------------------------------------------------------------------------
module firlc_dp import firlc_pkg::*; #(
	parameter int MAX_TAPS    = MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int AW = addr_bits(MAX_TAPS)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dp_cmd_t                cmd,
	input  wire logic [AW-1:0]          coef_raddr,
	output dp_sts_t                     sts,
	input  wire logic [IDX_W-1:0]       in_index,
	input  wire logic [SAMPLE_BITS-1:0] in_value,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [SAMPLE_BITS-1:0] out_data,
	output logic                        out_last,
	output logic                        out_clip
);

	localparam int SB    = SAMPLE_BITS;
	localparam int PW    = 2 * SB;
	// full sum width, capped at 63 bits for the saturating accumulator
	localparam int FULLW = PW + $clog2(MAX_TAPS) + 1;
	localparam int ACC_W = (FULLW < 63) ? FULLW : 63;

	localparam logic [ACC_W:0]   RND_ONE = (ACC_W + 1)'(1) << (SB - 2);
	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};
	localparam logic [SB-1:0]    OUT_MAX = {1'b0, {(SB - 1){1'b1}}};
	localparam logic [SB-1:0]    OUT_MIN = {1'b1, {(SB - 1){1'b0}}};

	// history pointers and valid bits
	logic [AW-1:0]       head_q, rp_q;
	logic [MAX_TAPS-1:0] hvld_q;

	logic [SB-1:0] hist_wdata, hist_rd, coef_rd;
	logic          coef_we;

	// mac pipeline
	logic                 iss_s1, first_s1, ltap_s1, hvld_s1;
	logic                 iss_s2, first_s2, ltap_s2;
	logic signed [PW-1:0] prod_s2;
	logic                 done_s3;
	logic [ACC_W-1:0]     acc_q;
	logic                 clip_q;

	logic signed [SB-1:0] coef_s, hist_s;
	logic [ACC_W-1:0]     acc_base;
	logic [ACC_W:0]       acc_sum;
	logic                 acc_ovf;

	// rounding
	logic signed [ACC_W:0] rnd_sum, rnd_shf;
	logic                  rnd_hi, rnd_lo;
	logic [SB-1:0]         rnd_val;

	logic [SB-1:0] res_q;
	logic          res_clip_q, res_rdy_q;

	logic          out_vld_q, out_last_q, out_clip_q;
	logic [SB-1:0] out_data_q;

	assign coef_we    = cmd.coef_wr && (int'(in_index) < MAX_TAPS);
	assign hist_wdata = cmd.push_zero ? '0 : in_value;

	firlc_ram #(.WIDTH(SB), .DEPTH(MAX_TAPS)) u_coef_ram (
		.clk     (clk),
		.wr_en   (coef_we),
		.wr_addr (in_index[AW-1:0]),
		.wr_data (in_value),
		.rd_en   (cmd.issue),
		.rd_addr (coef_raddr),
		.rd_data (coef_rd)
	);

	firlc_ram #(.WIDTH(SB), .DEPTH(MAX_TAPS)) u_hist_ram (
		.clk     (clk),
		.wr_en   (cmd.hist_push),
		.wr_addr (head_q),
		.wr_data (hist_wdata),
		.rd_en   (cmd.issue),
		.rd_addr (rp_q),
		.rd_data (hist_rd)
	);

	// head and read pointer; the read walks back from the newest sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			rp_q   <= '0;
			hvld_q <= '0;
		end else begin
			if (cmd.hist_clear) begin
				head_q <= '0;
				hvld_q <= '0;
			end else if (cmd.hist_push) begin
				head_q         <= (head_q == AW'(MAX_TAPS - 1)) ? '0 : head_q + 1'b1;
				hvld_q[head_q] <= 1'b1;
			end
			if (cmd.hist_push) begin
				rp_q <= head_q;
			end else if (cmd.issue) begin
				rp_q <= (rp_q == '0) ? AW'(MAX_TAPS - 1) : rp_q - 1'b1;
			end
		end
	end

	// control side of the mac pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1   <= 1'b0;
			first_s1 <= 1'b0;
			ltap_s1  <= 1'b0;
			hvld_s1  <= 1'b0;
			iss_s2   <= 1'b0;
			first_s2 <= 1'b0;
			ltap_s2  <= 1'b0;
			done_s3  <= 1'b0;
		end else begin
			iss_s1   <= cmd.issue;
			first_s1 <= cmd.first;
			ltap_s1  <= cmd.last_tap;
			hvld_s1  <= hvld_q[rp_q];
			iss_s2   <= iss_s1;
			first_s2 <= first_s1;
			ltap_s2  <= ltap_s1;
			done_s3  <= iss_s2 && ltap_s2;
		end
	end

	// slots never written since the last clear read as zero
	assign coef_s = coef_rd;
	assign hist_s = hvld_s1 ? hist_rd : '0;

	always_ff @(posedge clk) begin
		if (iss_s1) begin
			prod_s2 <= coef_s * hist_s;
		end
	end

	// saturating accumulate
	assign acc_base = first_s2 ? '0 : acc_q;
	assign acc_sum  = {acc_base[ACC_W-1], acc_base}
	                + {{(ACC_W + 1 - PW){prod_s2[PW-1]}}, prod_s2};
	assign acc_ovf  = acc_sum[ACC_W] != acc_sum[ACC_W-1];

	always_ff @(posedge clk) begin
		if (iss_s2) begin
			if (acc_ovf) begin
				acc_q <= acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
			end else begin
				acc_q <= acc_sum[ACC_W-1:0];
			end
			clip_q <= (first_s2 ? 1'b0 : clip_q) | acc_ovf;
		end
	end

	// round half up, floor shift, saturate
	assign rnd_sum = $signed({acc_q[ACC_W-1], acc_q} + RND_ONE);
	assign rnd_shf = rnd_sum >>> (SB - 1);
	assign rnd_hi  = !rnd_shf[ACC_W] && (|rnd_shf[ACC_W-1:SB-1]);
	assign rnd_lo  = rnd_shf[ACC_W] && !(&rnd_shf[ACC_W-1:SB-1]);

	always_comb begin
		if (rnd_hi) begin
			rnd_val = OUT_MAX;
		end else if (rnd_lo) begin
			rnd_val = OUT_MIN;
		end else begin
			rnd_val = rnd_shf[SB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (done_s3) begin
			res_q      <= rnd_val;
			res_clip_q <= clip_q | rnd_hi | rnd_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_rdy_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (done_s3) begin
				res_rdy_q <= 1'b1;
			end else if (cmd.out_load) begin
				res_rdy_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= res_q;
			out_clip_q <= res_clip_q;
			out_last_q <= cmd.out_last;
		end
	end

	assign sts.res_rdy  = res_rdy_q;
	assign sts.out_free = !out_vld_q || out_ready;

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;
	assign out_clip  = out_clip_q;

endmodule
`default_nettype wire

### design/fir_linear_convolution.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fir_linear_convolution
// streaming direct-form fir giving the full linear convolution of a sample
// block with a loaded impulse response
// ----------------------------------------------------------------------------
// usage
//  - slave side: tuser selects the item kind (0 coefficient load, 1 sample);
//    tdata carries tap_index and value; tlast marks the last sample of a block
//  - a load transfer writes one coefficient and gives no output
//  - each sample transfer gives one output; after the last sample of a block
//    taps-1 tail outputs follow, the final one with tlast high, and then the
//    history line is emptied for the next block
//  - one shared multiply-accumulate walks the taps one per cycle out of the
//    coefficient and history rams; each output passes the ram read, product,
//    accumulator and result registers, and the block takes the next item only
//    once the previous result (and any tail) has moved into the output register
//  - master side: tdata is the rounded, saturated q1.15 output, tuser flags
//    saturation; the output register holds a result while tready is low, and
//    the next item is already being worked on behind it
//  - cfg_we writes tap_count (zero acts as one, above MAX_TAPS as MAX_TAPS);
//    write it only while the block is idle
//  - arst_n resets control, empties the history and sets tap_count to 64;
//    coefficients must be loaded before use
// ----------------------------------------------------------------------------
module fir_linear_convolution import firlc_pkg::*; #(
	parameter int MAX_TAPS    = MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int S_DW = ((IDX_W + SAMPLE_BITS + 7) / 8) * 8,
	localparam int M_DW = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_we,
	input  wire logic [TAPC_W-1:0] cfg_wdata,    // tap_count
	// input stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [S_DW-1:0]   s_tdata,      // tap_index, value, zero pad
	input  wire logic              s_tuser,      // action
	input  wire logic              s_tlast,      // block_end
	// output stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [M_DW-1:0]   m_tdata,      // sample_out, zero pad
	output logic                   m_tuser,      // clipped
	output logic                   m_tlast       // is_last
);

	localparam int AW = addr_bits(MAX_TAPS);

	dp_cmd_t                cmd;
	dp_sts_t                sts;
	logic [AW-1:0]          coef_raddr;
	logic [SAMPLE_BITS-1:0] out_data;

	// sequencer: accepts transfers, walks the taps, counts tail outputs
	firlc_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_action  (s_tuser),
		.in_end     (s_tlast),
		.cmd        (cmd),
		.coef_raddr (coef_raddr),
		.sts        (sts)
	);

	// stores, mac, rounding and output register
	firlc_dp #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.coef_raddr (coef_raddr),
		.sts        (sts),
		.in_index   (s_tdata[IDX_W-1:0]),
		.in_value   (s_tdata[IDX_W+SAMPLE_BITS-1:IDX_W]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_data),
		.out_last   (m_tlast),
		.out_clip   (m_tuser)
	);

	// zero pad the output to whole bytes
	assign m_tdata = M_DW'(out_data);

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the linear convolution fir: coefficient loads and
// sample blocks go in over the slave stream; every output transfer is checked
// against a cycle-free model of the convolution, under random stalls on both
// streams and over a range of tap counts
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [firlc_pkg::SAMPLE_BITS_DEF-1:0] sample_out;
	logic                                  is_last;
	logic                                  clipped;
} conv_result_t;

// convolution model plus the queue of outputs it has predicted
class convolution_checker;
	localparam int NTAPS = firlc_pkg::MAX_TAPS_DEF;
	localparam int SB    = firlc_pkg::SAMPLE_BITS_DEF;
	localparam longint OUT_HI = (longint'(1) <<< (SB - 1)) - 1;
	localparam longint OUT_LO = -OUT_HI - 1;

	logic signed [SB-1:0] coeff [NTAPS];
	logic signed [SB-1:0] history [NTAPS];
	bit coeff_written [NTAPS];
	bit [firlc_pkg::IDX_W-1:0] head;
	int taps;
	conv_result_t expected_outputs [$];
	int errors, checked, loads, samples, blocks, clips;

	function new();
		foreach (history[i]) begin
			history[i] = '0;
			coeff[i] = '0;
			coeff_written[i] = 1'b0;
		end
		head = '0;
		taps = NTAPS;
	endfunction

	function void set_tap_count(logic [firlc_pkg::TAPC_W-1:0] v);
		taps = (v == 0) ? 1 : (v > NTAPS) ? NTAPS : int'(v);
	endfunction

	// one output: shift the sample in, sum over the taps, round half up, saturate
	function void shift_and_sum(logic signed [SB-1:0] s, bit last);
		longint acc;
		longint q;
		bit clip;
		bit [firlc_pkg::IDX_W-1:0] pos;
		conv_result_t r;
		history[head] = s;
		acc = 0;
		for (int k = 0; k < taps; k++) begin
			pos = head - k[firlc_pkg::IDX_W-1:0];
			acc += longint'(coeff[k]) * longint'(history[pos]);
		end
		head = head + 1'b1;
		q = (acc + (longint'(1) <<< (SB - 2))) >>> (SB - 1);
		clip = 1'b0;
		if (q > OUT_HI) begin
			q = OUT_HI;
			clip = 1'b1;
		end
		if (q < OUT_LO) begin
			q = OUT_LO;
			clip = 1'b1;
		end
		r.sample_out = q[SB-1:0];
		r.is_last = last;
		r.clipped = clip;
		expected_outputs = {expected_outputs, r};
	endfunction

	function void note_transfer(logic act, logic [firlc_pkg::IDX_W-1:0] idx,
			logic signed [SB-1:0] val, logic blk_end);
		if (act == firlc_pkg::ACT_LOAD) begin
			coeff[idx] = val;
			coeff_written[idx] = 1'b1;
			loads++;
			return;
		end
		samples++;
		if (!blk_end) begin
			shift_and_sum(val, 1'b0);
			return;
		end
		blocks++;
		shift_and_sum(val, taps == 1);
		for (int t = 1; t < taps; t++)
			shift_and_sum('0, t + 1 == taps);
		foreach (history[i])
			history[i] = '0;
		head = '0;
	endfunction

	function void check_transfer(logic [SB-1:0] data, logic last, logic clip);
		conv_result_t exp_r;
		if (expected_outputs.size() == 0) begin
			$error("output transfer with no result pending: sample_out %0d", $signed(data));
			errors++;
			return;
		end
		exp_r = expected_outputs.pop_front();
		checked++;
		if (exp_r.clipped)
			clips++;
		if (data !== exp_r.sample_out) begin
			$error("sample_out: expected %0d, got %0d", $signed(exp_r.sample_out),
				$signed(data));
			errors++;
		end
		if (last !== exp_r.is_last) begin
			$error("is_last: expected %0b, got %0b", exp_r.is_last, last);
			errors++;
		end
		if (clip !== exp_r.clipped) begin
			$error("clipped: expected %0b, got %0b", exp_r.clipped, clip);
			errors++;
		end
	endfunction
endclass

module testbench;
	import firlc_pkg::*;

	localparam int SB    = SAMPLE_BITS_DEF;
	localparam int S_DW  = ((IDX_W + SB + 7) / 8) * 8;
	localparam int M_DW  = ((SB + 7) / 8) * 8;
	// margin covering the longest output latency and a load still in flight
	localparam int DRAIN_CYCLES = MAX_TAPS_DEF + 16;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [TAPC_W-1:0] cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [S_DW-1:0]   s_tdata;      // tap_index, value, zero pad
	logic              s_tuser;      // action
	logic              s_tlast;      // block_end
	logic              m_tvalid;
	logic              m_tready;
	logic [M_DW-1:0]   m_tdata;      // sample_out, zero pad
	logic              m_tuser;      // clipped
	logic              m_tlast;      // is_last

	convolution_checker conv;
	int burst_left = 0;
	int rx_cycle = 0;
	int rx_mode = 0;
	int rx_hold = 0;

	fir_linear_convolution DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #2 clk = ~clk;

	// output side: check every transfer and stall m_tready in one of four randomly chosen modes
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid && m_tready)
			conv.check_transfer(m_tdata[SB-1:0], m_tlast, m_tuser);
		rx_cycle++;
		if (rx_cycle % 150 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) == 1);
			2: m_tready <= (rx_cycle % 5 == 0);
			default: begin
				if (rx_hold > 0) begin
					rx_hold--;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
					if ($urandom_range(0, 9) == 0)
						rx_hold = $urandom_range(4, 24);
				end
			end
		endcase
	end

	// one input transfer; a new burst may open with a gap of random length
	task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
			input logic signed [SB-1:0] val, input logic blk_end);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 :
				($urandom_range(0, 5) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tlast  <= blk_end;
		s_tdata  <= {{(S_DW - IDX_W - SB){1'b0}}, val, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		conv.note_transfer(act, idx, val, blk_end);
	endtask

	// wait until every predicted output has gone out and the block is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (conv.expected_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tap_count(input logic [TAPC_W-1:0] v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		conv.set_tap_count(v);
	endtask

	function automatic logic signed [SB-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(0, 63)) - 16'sd32;
			default: return 16'($urandom());
		endcase
	endfunction

	// every tap in use must hold a written coefficient before samples arrive
	task automatic load_missing_coeffs(input int n);
		for (int i = 0; i < n; i++)
			if (!conv.coeff_written[i])
				send_item(ACT_LOAD, i[IDX_W-1:0], pick_value(), 1'($urandom_range(0, 1)));
	endtask

	// mostly well-formed blocks with random content; coefficient reloads between
	// and now and then inside blocks, and the last block may stay open
	task automatic run_phase(input logic [TAPC_W-1:0] tap_setting, input int n_items);
		int sent;
		int blen;
		int nload;
		settle();
		write_tap_count(tap_setting);
		load_missing_coeffs(conv.taps);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 3) == 0) begin
				nload = $urandom_range(1, 4);
				for (int j = 0; j < nload; j++) begin
					send_item(ACT_LOAD, IDX_W'($urandom_range(0, 63)), pick_value(),
						1'($urandom_range(0, 1)));
					sent++;
				end
			end
			blen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			for (int i = 0; i < blen && sent < n_items; i++) begin
				if ($urandom_range(0, 15) == 0) begin
					send_item(ACT_LOAD, IDX_W'($urandom_range(0, 63)), pick_value(), 1'b0);
					sent++;
				end
				send_item(ACT_SAMPLE, IDX_W'($urandom_range(0, 63)), pick_value(),
					i == blen - 1);
				sent++;
			end
		end
	endtask

	initial begin
		conv      = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = ACT_LOAD;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset tap count of 64
		load_missing_coeffs(MAX_TAPS_DEF);
		send_item(ACT_LOAD, 6'd0, 16'sh8000, 1'b1);      // load carrying block_end
		send_item(ACT_LOAD, 6'd1, 16'sh8000, 1'b0);
		send_item(ACT_LOAD, 6'd63, 16'sh7fff, 1'b0);     // highest tap index
		send_item(ACT_SAMPLE, 6'd0, 16'sh7fff, 1'b0);
		send_item(ACT_SAMPLE, 6'd63, 16'sh7fff, 1'b0);   // negative saturation
		send_item(ACT_SAMPLE, 6'd5, 16'sh8000, 1'b0);
		send_item(ACT_SAMPLE, 6'd42, 16'sh8000, 1'b0);   // positive saturation
		send_item(ACT_SAMPLE, 6'd0, 16'sh0000, 1'b1);    // full tail of 63 outputs
		send_item(ACT_LOAD, 6'd0, 16'sh4000, 1'b0);      // one half, rounding ties
		send_item(ACT_SAMPLE, 6'd0, 16'sh0001, 1'b1);    // block of a single sample
		send_item(ACT_SAMPLE, 6'd0, 16'shffff, 1'b1);

		// tap count zero acts as a single tap: is_last on the first output
		settle();
		write_tap_count(7'd0);
		send_item(ACT_SAMPLE, 6'd63, 16'sh7fff, 1'b1);
		send_item(ACT_SAMPLE, 6'd0, 16'sh8000, 1'b0);
		send_item(ACT_SAMPLE, 6'd21, 16'sd5, 1'b1);

		// random part over several tap counts, out-of-range settings included
		run_phase(7'd127, 24);
		run_phase(7'd1, 24);
		run_phase(7'd2, 24);
		run_phase(7'd64, 24);
		run_phase(7'd5, 24);
		run_phase(7'd17, 24);
		run_phase(7'd0, 24);
		run_phase(7'd40, 24);
		run_phase(TAPC_W'($urandom_range(1, 63)), 24);
		run_phase(7'd3, 24);
		settle();

		$display("covered %0d coefficient loads and %0d samples in %0d closed blocks",
			conv.loads, conv.samples, conv.blocks);
		$display("checked %0d outputs (%0d saturated) over tap counts 0 to 127, %0d mismatches",
			conv.checked, conv.clips, conv.errors);
		if (conv.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#50ms;
		$display("status: fail");
		$finish;
	end

endmodule
